// ===== hw/rtl/old_pkg.sv =====
package old_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 3;
	localparam int POS_W     = 16;
	localparam int STATUS_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND     = 3'd0,
		CMD_POP_HEAD   = 3'd1,
		CMD_POP_TAIL   = 3'd2,
		CMD_REMOVE_AT  = 3'd3,
		CMD_REMOVE_VAL = 3'd4,
		CMD_READ       = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_RANGE    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_SHIFT,
		S_SCAN
	} fsm_t;

endpackage

// ===== hw/rtl/old_if.sv =====
interface old_in_if;
	import old_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic signed [DATA_W-1:0]  item_value;
	logic [POS_W-1:0]          position;

	modport source (output valid, output command, output item_value, output position,
		input ready);
	modport sink (input valid, input command, input item_value, input position,
		output ready);
endinterface

interface old_out_if #(
	parameter int DEPTH = old_pkg::DEPTH_DEF
);
	import old_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [DATA_W-1:0]  result_value;
	logic [CNT_W-1:0]          entry_count;

	modport source (output valid, output status, output result_value, output entry_count,
		input ready);
	modport sink (input valid, input status, input result_value, input entry_count,
		output ready);
endinterface

// ===== hw/rtl/ordered_list_delete_engine_unit.sv =====
// Append, unused codes and the empty, range and full errors answer in the cycle after acceptance.
// A read fetches the entry at position i (from 1); removing it fetches it and then shifts each
// later entry one place nearer the head. Removal by value scans from the head; a miss scans all entries.
// One command is in flight at a time; the next can be taken at the edge its result beat leaves.
// Reset clears the count and the result valid flag; the result fields and the entry memory are not cleared.
module ordered_list_delete_engine_unit #(
	parameter int DEPTH = old_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	old_in_if.sink    cmd_ch,
	old_out_if.source res_ch
);
	import old_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic              mem_wr_en;
	logic [AW-1:0]     mem_wr_addr;
	logic [DATA_W-1:0] mem_wr_data;
	logic [AW-1:0]     mem_rd_addr;
	logic [DATA_W-1:0] mem_rd_data;

	old_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	old_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_ch      (cmd_ch),
		.res_ch      (res_ch),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid |-> (res_ch.entry_count <= CNT_W'(DEPTH)))
		else $error("entry count above depth");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && (res_ch.status != ST_OK)) |-> (res_ch.result_value == '0))
		else $error("non-zero value on an error beat");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && (res_ch.status == ST_FULL)) |-> (res_ch.entry_count == CNT_W'(DEPTH)))
		else $error("list full reported below depth");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && (res_ch.status == ST_EMPTY)) |-> (res_ch.entry_count == '0))
		else $error("list empty reported with entries present");
`endif

endmodule

// ===== hw/rtl/old_mem.sv =====
module old_mem #(
	parameter int DEPTH = old_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [old_pkg::DATA_W-1:0] wr_data,
	input  logic [AW-1:0]             rd_addr,
	output logic [old_pkg::DATA_W-1:0] rd_data
);
	import old_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hw/rtl/old_ctrl.sv =====
module old_ctrl #(
	parameter int DEPTH = old_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	old_in_if.sink                     cmd_ch,
	old_out_if.source                  res_ch,
	output logic                       mem_wr_en,
	output logic [AW-1:0]              mem_wr_addr,
	output logic [old_pkg::DATA_W-1:0] mem_wr_data,
	output logic [AW-1:0]              mem_rd_addr,
	input  logic [old_pkg::DATA_W-1:0] mem_rd_data
);
	import old_pkg::*;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	fsm_t              state_q, state_d;
	logic [CNT_W-1:0]  len_q, len_d;
	logic [AW-1:0]     addr_q, addr_d;
	logic [AW-1:0]     next_addr;
	logic [DATA_W-1:0] key_q, key_d;
	logic              take_q, take_d;
	logic [DATA_W-1:0] removed_q, removed_d;
	logic              more;
	logic              accept;
	logic              pos_bad;
	logic              list_empty;

	logic              fin;
	status_t           fin_status;
	logic [DATA_W-1:0] fin_value;
	logic [CNT_W-1:0]  fin_count;

	logic              res_valid_q;
	status_t           res_status_q;
	logic [DATA_W-1:0] res_value_q;
	logic [CNT_W-1:0]  res_count_q;

	assign cmd_ch.ready = (state_q == S_IDLE) && (!res_valid_q || res_ch.ready);
	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign next_addr    = addr_q + AW'(1);
	assign more         = (CNT_W'(addr_q) + CNT_W'(1)) < len_q;
	assign list_empty   = (len_q == '0);
	assign pos_bad      = (cmd_ch.position == '0) || (32'(cmd_ch.position) > 32'(len_q));

	always_comb begin
		state_d     = state_q;
		len_d       = len_q;
		addr_d      = addr_q;
		key_d       = key_q;
		take_d      = take_q;
		removed_d   = removed_q;
		fin         = 1'b0;
		fin_status  = ST_OK;
		fin_value   = '0;
		fin_count   = len_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = addr_q - AW'(1);
		mem_wr_data = mem_rd_data;
		mem_rd_addr = next_addr;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					fin = 1'b1;
					unique case (cmd_ch.command) inside
						CMD_APPEND: begin
							if (len_q == FULL_CNT) begin
								fin_status = ST_FULL;
							end else begin
								mem_wr_en   = 1'b1;
								mem_wr_addr = AW'(len_q);
								mem_wr_data = cmd_ch.item_value;
								len_d       = len_q + CNT_W'(1);
								fin_count   = len_q + CNT_W'(1);
							end
						end
						CMD_POP_HEAD, CMD_POP_TAIL: begin
							if (list_empty) begin
								fin_status = ST_EMPTY;
							end else begin
								fin         = 1'b0;
								take_d      = 1'b1;
								state_d     = S_FETCH;
								mem_rd_addr = (cmd_ch.command == CMD_POP_HEAD) ? '0
									: AW'(len_q - CNT_W'(1));
								addr_d      = mem_rd_addr;
							end
						end
						CMD_REMOVE_AT, CMD_READ: begin
							if (list_empty) begin
								fin_status = ST_EMPTY;
							end else if (pos_bad) begin
								fin_status = ST_RANGE;
							end else begin
								fin         = 1'b0;
								take_d      = (cmd_ch.command == CMD_REMOVE_AT);
								state_d     = S_FETCH;
								mem_rd_addr = AW'(cmd_ch.position - POS_W'(1));
								addr_d      = mem_rd_addr;
							end
						end
						CMD_REMOVE_VAL: begin
							if (list_empty) begin
								fin_status = ST_EMPTY;
							end else begin
								fin         = 1'b0;
								key_d       = cmd_ch.item_value;
								state_d     = S_SCAN;
								mem_rd_addr = '0;
								addr_d      = '0;
							end
						end
						default: begin
							// Unused codes leave the list alone and report ok.
							fin_status = ST_OK;
						end
					endcase
				end
			end
			S_FETCH: begin
				removed_d = mem_rd_data;
				if (!take_q) begin
					fin       = 1'b1;
					fin_value = mem_rd_data;
					state_d   = S_IDLE;
				end else if (more) begin
					addr_d  = next_addr;
					state_d = S_SHIFT;
				end else begin
					fin       = 1'b1;
					fin_value = mem_rd_data;
					len_d     = len_q - CNT_W'(1);
					fin_count = len_q - CNT_W'(1);
					state_d   = S_IDLE;
				end
			end
			S_SHIFT: begin
				// Data of entry addr_q lands one place nearer the head.
				mem_wr_en = 1'b1;
				if (more) begin
					addr_d = next_addr;
				end else begin
					fin       = 1'b1;
					fin_value = removed_q;
					len_d     = len_q - CNT_W'(1);
					fin_count = len_q - CNT_W'(1);
					state_d   = S_IDLE;
				end
			end
			S_SCAN: begin
				if (mem_rd_data == key_q) begin
					removed_d = mem_rd_data;
					if (more) begin
						addr_d  = next_addr;
						state_d = S_SHIFT;
					end else begin
						fin       = 1'b1;
						fin_value = mem_rd_data;
						len_d     = len_q - CNT_W'(1);
						fin_count = len_q - CNT_W'(1);
						state_d   = S_IDLE;
					end
				end else if (more) begin
					addr_d = next_addr;
				end else begin
					fin        = 1'b1;
					fin_status = ST_NOTFOUND;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			len_q <= len_d;
			if (fin) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q    <= addr_d;
		key_q     <= key_d;
		take_q    <= take_d;
		removed_q <= removed_d;
		if (fin) begin
			res_status_q <= fin_status;
			res_value_q  <= fin_value;
			res_count_q  <= fin_count;
		end
	end

	assign res_ch.valid        = res_valid_q;
	assign res_ch.status       = res_status_q;
	assign res_ch.result_value = res_value_q;
	assign res_ch.entry_count  = res_count_q;

endmodule
